FILE: hw/rtl/ucv_pkg.sv
// ----------------------------------------------------------------------------
// ucv_pkg: shared types and constants for the control code visualiser
// Transaction structs, sequencer and encoder types, code point constants.
// ----------------------------------------------------------------------------
package ucv_pkg;

    localparam int CP_W  = 31;
    localparam int GRP_W = 6;
    localparam int SH_W  = 36;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EMIT
    } t_seq_state;

    typedef enum logic [1:0] {
        EM_ASCII,
        EM_ESC,
        EM_MULTI
    } t_enc_mode;

    typedef struct packed {
        logic load;
        logic adv;
    } t_enc_ctl;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       final_byte;
    } t_enc_sts;

    localparam logic [CP_W-1:0] CP_TAB      = 31'h09;
    localparam logic [CP_W-1:0] CP_LF       = 31'h0A;
    localparam logic [CP_W-1:0] CP_CR       = 31'h0D;
    localparam logic [CP_W-1:0] CP_C0_END   = 31'h20;
    localparam logic [CP_W-1:0] CP_DEL      = 31'h7F;
    localparam logic [CP_W-1:0] CP_C1_LO    = 31'h80;
    localparam logic [CP_W-1:0] CP_C1_END   = 31'hA0;
    localparam logic [CP_W-1:0] CP_PIC_BASE = 31'h2400;
    localparam logic [CP_W-1:0] CP_PIC_DEL  = 31'h2421;
    localparam logic [CP_W-1:0] CP_LIM_2    = 31'h800;
    localparam logic [CP_W-1:0] CP_LIM_3    = 31'h10000;
    localparam logic [CP_W-1:0] CP_LIM_4    = 31'h200000;
    localparam logic [CP_W-1:0] CP_LIM_5    = 31'h4000000;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A_LC   = 8'h61;
    localparam logic [7:0] CONT_TAG  = 8'h80;

endpackage

FILE: hw/rtl/ucv_enc.sv
// ----------------------------------------------------------------------------
// ucv_enc: code point visual encoder
// Maps a code point to its visible form, serialised one byte per adv cycle.
// ----------------------------------------------------------------------------
module ucv_enc import ucv_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_enc_ctl        i_ctl,
    input  logic [CP_W-1:0] i_cp,
    output t_enc_sts        o_sts
);

    function automatic logic [CP_W-1:0] remap(input logic [CP_W-1:0] x);
        logic [CP_W-1:0] r;
        unique case (x)
            31'h2028: r = 31'h21B5;
            31'h2029: r = 31'h00B6;
            31'h202A: r = 31'h27EB;
            31'h202B: r = 31'h27EA;
            31'h202C: r = 31'h21EE;
            31'h202D: r = 31'h276F;
            31'h202E: r = 31'h276E;
            31'h2066: r = 31'h27E9;
            31'h2067: r = 31'h27E8;
            31'h2068: r = 31'h29FD;
            31'h2069: r = 31'h21EF;
            default:  r = x;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = CH_ZERO + {4'd0, n};
        end else begin
            c = CH_A_LC + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

    logic [CP_W-1:0] v;
    logic [SH_W-1:0] v_ext;
    logic [SH_W-1:0] sh_load;
    logic [2:0]      k_load;
    t_enc_mode       mode_load;

    t_enc_mode       r_mode;
    logic [2:0]      r_pos;
    logic [2:0]      r_k;
    logic [SH_W-1:0] r_sh;
    logic [7:0]      prefix;

    always_comb begin
        v = remap(i_cp);
        mode_load = EM_MULTI;
        if (v >= CP_C1_LO && v < CP_C1_END) begin
            mode_load = EM_ESC;
        end else begin
            if (v < CP_C0_END) begin
                if (v != CP_TAB && v != CP_CR && v != CP_LF) begin
                    v = v + CP_PIC_BASE;
                end
            end else if (v == CP_DEL) begin
                v = CP_PIC_DEL;
            end
            if (v < CP_C1_LO) begin
                mode_load = EM_ASCII;
            end
        end
        priority if (v < CP_LIM_2) begin
            k_load = 3'd2;
        end else if (v < CP_LIM_3) begin
            k_load = 3'd3;
        end else if (v < CP_LIM_4) begin
            k_load = 3'd4;
        end else if (v < CP_LIM_5) begin
            k_load = 3'd5;
        end else begin
            k_load = 3'd6;
        end
        v_ext = {{(SH_W-CP_W){1'b0}}, v};
        if (mode_load != EM_MULTI) begin
            sh_load = v_ext;
        end else begin
            unique case (k_load)
                3'd2:    sh_load = v_ext << (4 * GRP_W);
                3'd3:    sh_load = v_ext << (3 * GRP_W);
                3'd4:    sh_load = v_ext << (2 * GRP_W);
                3'd5:    sh_load = v_ext << GRP_W;
                default: sh_load = v_ext;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= EM_ASCII;
            r_pos  <= 3'd0;
        end else if (i_ctl.load) begin
            r_mode <= mode_load;
            r_pos  <= 3'd0;
        end else if (i_ctl.adv) begin
            r_pos  <= r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_k  <= k_load;
            r_sh <= sh_load;
        end else if (i_ctl.adv && r_mode == EM_MULTI) begin
            r_sh <= r_sh << GRP_W;
        end
    end

    always_comb begin
        unique case (r_k)
            3'd2:    prefix = 8'hC0;
            3'd3:    prefix = 8'hE0;
            3'd4:    prefix = 8'hF0;
            3'd5:    prefix = 8'hF8;
            default: prefix = 8'hFC;
        endcase
        unique case (r_mode)
            EM_ESC: begin
                unique case (r_pos)
                    3'd0:    o_sts.byte_val = CH_BSLASH;
                    3'd1:    o_sts.byte_val = CH_U;
                    3'd2:    o_sts.byte_val = CH_ZERO;
                    3'd3:    o_sts.byte_val = CH_ZERO;
                    3'd4:    o_sts.byte_val = hex_char(r_sh[7:4]);
                    default: o_sts.byte_val = hex_char(r_sh[3:0]);
                endcase
                o_sts.final_byte = (r_pos == 3'd5);
            end
            EM_MULTI: begin
                o_sts.byte_val = ((r_pos == 3'd0) ? prefix : CONT_TAG)
                               | {2'b00, r_sh[SH_W-1 -: GRP_W]};
                o_sts.final_byte = (r_pos == r_k - 3'd1);
            end
            default: begin
                o_sts.byte_val   = r_sh[7:0];
                o_sts.final_byte = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/utf8_control_code_visualizer.sv
// ----------------------------------------------------------------------------
// utf8_control_code_visualizer: visible rendering of UTF-8 text
// Decodes legacy UTF-8 and re-emits it with controls and bidi marks shown.
//
//  channel | signals                        | transaction
//  --------+--------------------------------+------------------------------
//  in      | i_in_valid, o_in_ready, i_in   | one text byte, end flag
//  out     | o_out_valid, i_out_ready, o_out| one output byte, last flag
//
// An item that gives no output leaves the sequencer idle. Otherwise, after its
// acceptance, each code point it releases (up to six) is loaded into the
// encoder and then serialised, one to six output bytes per code point.
// For an item that gives output, o_in_ready is low from acceptance until the
// last byte sits in the output register. Output stalls hold the encoder.
// Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module utf8_control_code_visualizer import ucv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_seq_state      r_state, n_state;

    logic            r_pend, n_pend;
    logic [7:0]      r_lead, n_lead;
    logic [2:0]      r_need, n_need;
    logic [2:0]      r_held, n_held;
    logic [CP_W-1:0] r_acc, n_acc;
    logic [5:0]      r_held_data [4];

    logic [7:0]      r_fl_lead;
    logic [2:0]      r_nfl, n_nfl;
    logic            r_xv, n_xv;
    logic [CP_W-1:0] r_x, n_x;
    logic [2:0]      r_idx;
    logic            r_cp_last;

    t_out            r_out;
    logic            r_out_valid;

    logic            in_acc;
    logic            wr_held;
    logic            is_cont;
    logic [2:0]      held_p1;
    logic [CP_W-1:0] acc_nx;
    logic [7:0]      b;
    logic [2:0]      total;
    logic [2:0]      total_nx;
    logic [2:0]      idx_m1;
    logic [CP_W-1:0] cp_sel;
    logic            cp_last;
    logic            idx_inc;
    t_enc_ctl        enc_ctl;
    t_enc_sts        enc_sts;

    assign in_acc = i_in_valid && o_in_ready;
    assign b      = i_in.in_byte;

    always_comb begin
        is_cont = (b[7:6] == 2'b10);
        held_p1 = r_held + 3'd1;
        acc_nx  = {r_acc[CP_W-GRP_W-1:0], b[5:0]};
        n_pend  = r_pend;
        n_lead  = r_lead;
        n_need  = r_need;
        n_held  = r_held;
        n_acc   = r_acc;
        n_nfl   = 3'd0;
        n_xv    = 1'b0;
        n_x     = {{(CP_W-8){1'b0}}, b};
        wr_held = 1'b0;
        if (r_pend && is_cont) begin
            if (held_p1 >= r_need) begin
                n_xv   = 1'b1;
                n_x    = acc_nx;
                n_pend = 1'b0;
                n_held = 3'd0;
                n_need = 3'd0;
                n_acc  = '0;
            end else begin
                wr_held = 1'b1;
                n_held  = held_p1;
                n_acc   = acc_nx;
                if (i_in.text_end) begin
                    n_nfl  = held_p1 + 3'd1;
                    n_pend = 1'b0;
                    n_held = 3'd0;
                    n_need = 3'd0;
                    n_acc  = '0;
                end
            end
        end else begin
            if (r_pend) begin
                n_nfl = held_p1;
            end
            if (b[7:6] != 2'b11 || i_in.text_end) begin
                n_xv   = 1'b1;
                n_pend = 1'b0;
                n_held = 3'd0;
                n_need = 3'd0;
                n_acc  = '0;
            end else begin
                n_pend = 1'b1;
                n_lead = b;
                n_held = 3'd0;
                priority if (b < 8'hE0) begin
                    n_need = 3'd1;
                    n_acc  = {{(CP_W-5){1'b0}}, b[4:0]};
                end else if (b < 8'hF0) begin
                    n_need = 3'd2;
                    n_acc  = {{(CP_W-4){1'b0}}, b[3:0]};
                end else if (b < 8'hF8) begin
                    n_need = 3'd3;
                    n_acc  = {{(CP_W-3){1'b0}}, b[2:0]};
                end else if (b < 8'hFC) begin
                    n_need = 3'd4;
                    n_acc  = {{(CP_W-2){1'b0}}, b[1:0]};
                end else begin
                    n_need = 3'd5;
                    n_acc  = {{(CP_W-2){1'b0}}, b[1:0]};
                end
            end
        end
        total_nx = n_nfl + {2'b00, n_xv};
    end

    always_comb begin
        total   = r_nfl + {2'b00, r_xv};
        idx_m1  = r_idx - 3'd1;
        cp_last = (r_idx == total - 3'd1);
        if (r_idx < r_nfl) begin
            if (r_idx == 3'd0) begin
                cp_sel = {{(CP_W-8){1'b0}}, r_fl_lead};
            end else begin
                cp_sel = {{(CP_W-8){1'b0}}, 2'b10, r_held_data[idx_m1[1:0]]};
            end
        end else begin
            cp_sel = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        enc_ctl     = '0;
        idx_inc     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc && total_nx != 3'd0) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                enc_ctl.load = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                enc_ctl.adv = !r_out_valid || i_out_ready;
                if (enc_ctl.adv && enc_sts.final_byte) begin
                    if (r_cp_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        idx_inc = 1'b1;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_lead <= 8'd0;
            r_need <= 3'd0;
            r_held <= 3'd0;
            r_acc  <= '0;
            r_nfl  <= 3'd0;
            r_xv   <= 1'b0;
            r_idx  <= 3'd0;
        end else if (in_acc) begin
            r_pend <= n_pend;
            r_lead <= n_lead;
            r_need <= n_need;
            r_held <= n_held;
            r_acc  <= n_acc;
            r_nfl  <= n_nfl;
            r_xv   <= n_xv;
            r_idx  <= 3'd0;
        end else if (idx_inc) begin
            r_idx  <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fl_lead <= r_lead;
            r_x       <= n_x;
            if (wr_held) begin
                r_held_data[r_held[1:0]] <= b[5:0];
            end
        end
        if (enc_ctl.load) begin
            r_cp_last <= cp_last;
        end
    end

    ucv_enc u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (enc_ctl),
        .i_cp    (cp_sel),
        .o_sts   (enc_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (enc_ctl.adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enc_ctl.adv) begin
            r_out.out_byte <= enc_sts.byte_val;
            r_out.run_last <= enc_sts.final_byte && r_cp_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hw/rtl/ucv_chk.sv
// ----------------------------------------------------------------------------
// ucv_chk: port checker for the control code visualiser
// Watches the top level ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module ucv_chk import ucv_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output transaction changed while stalled");

    // no new input while an item still owes bytes
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.run_last |-> !o_in_ready)
        else $error("input ready while item incomplete");

    // output bytes come only from the busy sequencer
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("output byte without active item");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("bad state after reset");

endmodule

bind utf8_control_code_visualizer ucv_chk u_ucv_chk (.*);
